>>> design/rdl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdl_pkg: shared types and constants of the ROM DMA line loader
// Request and response payload structs, operation and result codes,
// register map words and the DMA line size.
// ----------------------------------------------------------------------------
package rdl_pkg;

   // dma line size in bytes, a power of two between 4 and 128
   localparam int LINE_BYTES = 64;
   localparam int LINE_OFS_W = $clog2(LINE_BYTES);
   localparam int LINE_W     = LINE_OFS_W + 1;

   // configuration port
   localparam int                    CSR_IDX_W       = 2;
   localparam int                    CSR_DATA_W      = 25;
   localparam int                    ROM_BYTES_W     = 25;
   localparam logic [ROM_BYTES_W-1:0] ROM_BYTES_RESET = 25'd65536;

   // depth of the result queue, most results one request can cause
   localparam int MAX_RESULTS = 3;
   localparam int RES_CNT_W   = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROM_BYTES     = 2'd0,
      CSR_RESET_CLIENT  = 2'd1,
      CSR_RESET_CHANNEL = 2'd2,
      CSR_OWN_DEVICE_ID = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      OP_REG_WRITE  = 2'd0,
      OP_ROM_READ   = 2'd1,
      OP_TICK       = 2'd2,
      OP_FLUSH_RESP = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_DMA_WRITE  = 3'd0,
      KIND_FLUSH_READ = 3'd1,
      KIND_NOTIFY     = 3'd2,
      KIND_READ_RESP  = 3'd3,
      KIND_ERROR      = 3'd4
   } kind_type;

   // bus register map, word index = byte address / 4
   localparam logic [3:0] WORD_START    = 4'd0;
   localparam logic [3:0] WORD_CLIENT   = 4'd1;
   localparam logic [3:0] WORD_ROM_LO   = 4'd2;
   localparam logic [3:0] WORD_ROM_HI   = 4'd3;
   localparam logic [3:0] WORD_DEST_LO  = 4'd4;
   localparam logic [3:0] WORD_DEST_HI  = 4'd5;
   localparam logic [3:0] WORD_LEN_LO   = 4'd6;
   localparam logic [3:0] WORD_LEN_HI   = 4'd7;
   localparam logic [63:0] REG_ADDR_MAX = 64'd32;
   localparam logic [7:0]  REG_SIZE     = 8'd4;

   typedef struct packed {
      op_type      op;
      logic [63:0] req_address;
      logic [31:0] write_value;
      logic [7:0]  req_size;
      logic [15:0] source_device;
      logic        write_ready;
      logic        read_ready;
      logic        notify_ready;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] target_device;
      logic [63:0] bus_address;
      logic [63:0] byte_offset;
      logic [7:0]  length;
      logic        last;
   } rsp_type;

   // build one result with the last flag clear
   function automatic rsp_type make_rsp(kind_type k, logic [15:0] target,
                                        logic [63:0] addr, logic [63:0] offset,
                                        logic [7:0] len);
      rsp_type r;
      r.kind          = k;
      r.target_device = target;
      r.bus_address   = addr;
      r.byte_offset   = offset;
      r.length        = len;
      r.last          = 1'b0;
      return r;
   endfunction

endpackage
`default_nettype wire

>>> design/rom_dma_line_loader.sv
// A request's first result is registered and offered in the cycle after its transfer.
// Throughput: one request per cycle while rsp_ready is high and each causes at most one
// result; one causing more holds the input as the queue drains, one a cycle on rsp_ready.
// Reset: clears the load, flush and notify flags, the range registers, the progress
// counter and the result queue, and returns the configuration registers to defaults.
`default_nettype none
// ----------------------------------------------------------------------------
// rom_dma_line_loader: ROM with a line-sized DMA load engine
// Decodes bus register writes, ROM reads, engine ticks and flush responses,
// issues DMA write descriptors, flush reads, notifications and errors.
// ----------------------------------------------------------------------------
module rom_dma_line_loader (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rdl_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rdl_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [rdl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rdl_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import rdl_pkg::*;

   // configuration registers
   logic [ROM_BYTES_W-1:0] rom_bytes_ff, rom_bytes_in;
   logic [15:0]            own_id_ff, own_id_in;

   // engine state
   logic        loading_ff, loading_in;
   logic        flushing_ff, flushing_in;
   logic        notifying_ff, notifying_in;
   logic [15:0] client_id_ff, client_id_in;
   logic [15:0] notify_ch_ff, notify_ch_in;
   logic [63:0] rom_start_ff, rom_start_in;
   logic [63:0] dest_start_ff, dest_start_in;
   logic [63:0] range_len_ff, range_len_in;
   logic [63:0] progress_ff, progress_in;

   // result queue, slot 0 is the head
   rsp_type              slot_ff [MAX_RESULTS];
   rsp_type              slot_in [MAX_RESULTS];
   logic [RES_CNT_W-1:0] count_ff, count_in;

   // request decode
   logic                   accept, pop;
   logic [63:0]            addr;
   logic [31:0]            val;
   logic [7:0]             size;
   logic [15:0]            src;
   logic [3:0]             word;
   logic                   wr_bad, rd_bad, resp_bad;
   logic [ROM_BYTES_W-1:0] rom_room;
   logic                   do_load, do_flush, do_notify;

   // dma chunk
   logic [63:0]       remain, dest, rom_ofs;
   logic [LINE_W-1:0] to_edge, chunk;
   logic [7:0]        chunk_len;
   logic              chunk_done;

   // results of the current request
   rsp_type              res [MAX_RESULTS];
   logic [RES_CNT_W-1:0] res_cnt;

   // handshakes
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = slot_ff[0];
   assign req_ready = (count_ff == '0) || ((count_ff == RES_CNT_W'(1)) && rsp_ready);
   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;

   // request fields
   assign addr = req_data.req_address;
   assign val  = req_data.write_value;
   assign size = req_data.req_size;
   assign src  = req_data.source_device;
   assign word = addr[5:2];

   // malformed register write, rom bounds, unexpected flush response
   assign wr_bad   = (addr[1:0] != 2'b00) || (addr > REG_ADDR_MAX) || (size != REG_SIZE);
   assign rom_room = rom_bytes_ff - addr[ROM_BYTES_W-1:0];
   assign rd_bad   = (addr >= {{(64-ROM_BYTES_W){1'b0}}, rom_bytes_ff}) ||
                     ({{(ROM_BYTES_W-8){1'b0}}, size} > rom_room);
   assign resp_bad = (src != client_id_ff) || (addr != 64'd0);

   // tick work acts on the flags as they stood before this tick
   assign do_load   = loading_ff && req_data.write_ready;
   assign do_flush  = flushing_ff && req_data.read_ready;
   assign do_notify = notifying_ff && req_data.notify_ready;

   // next chunk: min of remaining bytes and distance to the line boundary
   assign remain     = (progress_ff >= range_len_ff) ? 64'd0 : range_len_ff - progress_ff;
   assign dest       = dest_start_ff + progress_ff;
   assign rom_ofs    = rom_start_ff + progress_ff;
   assign to_edge    = LINE_W'(LINE_BYTES) - {1'b0, dest[LINE_OFS_W-1:0]};
   assign chunk      = (remain < {{(64-LINE_W){1'b0}}, to_edge}) ?
                       remain[LINE_W-1:0] : to_edge;
   assign chunk_len  = 8'(chunk);
   assign chunk_done = ({{(64-LINE_W){1'b0}}, chunk} >= remain);

   // collect the results of this request in order
   always_comb begin
      res_cnt = '0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res[i] = '0;
      end
      case (req_data.op)
         OP_REG_WRITE: begin
            if (wr_bad) begin
               res[res_cnt] = make_rsp(KIND_ERROR, src, addr, 64'd0, size);
               res_cnt      = res_cnt + RES_CNT_W'(1);
            end
         end
         OP_ROM_READ: begin
            if (rd_bad) begin
               res[res_cnt] = make_rsp(KIND_ERROR, src, addr, 64'd0, size);
            end else begin
               res[res_cnt] = make_rsp(KIND_READ_RESP, src, addr, addr, size);
            end
            res_cnt = res_cnt + RES_CNT_W'(1);
         end
         OP_TICK: begin
            if (do_load) begin
               res[res_cnt] = make_rsp(KIND_DMA_WRITE, client_id_ff, dest, rom_ofs,
                                       chunk_len);
               res_cnt      = res_cnt + RES_CNT_W'(1);
            end
            if (do_flush) begin
               res[res_cnt] = make_rsp(KIND_FLUSH_READ, client_id_ff, 64'd0, 64'd0, 8'd0);
               res_cnt      = res_cnt + RES_CNT_W'(1);
            end
            if (do_notify) begin
               res[res_cnt] = make_rsp(KIND_NOTIFY, notify_ch_ff, {48'd0, own_id_ff},
                                       64'd0, 8'd0);
               res_cnt      = res_cnt + RES_CNT_W'(1);
            end
         end
         OP_FLUSH_RESP: begin
            if (resp_bad) begin
               res[res_cnt] = make_rsp(KIND_ERROR, src, addr, 64'd0, size);
               res_cnt      = res_cnt + RES_CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
      if (res_cnt != '0) begin
         res[res_cnt - RES_CNT_W'(1)].last = 1'b1;
      end
   end

   // engine state update on a request transfer
   always_comb begin
      loading_in    = loading_ff;
      flushing_in   = flushing_ff;
      notifying_in  = notifying_ff;
      client_id_in  = client_id_ff;
      notify_ch_in  = notify_ch_ff;
      rom_start_in  = rom_start_ff;
      dest_start_in = dest_start_ff;
      range_len_in  = range_len_ff;
      progress_in   = progress_ff;
      if (accept) begin
         case (req_data.op)
            OP_REG_WRITE: begin
               if (!wr_bad) begin
                  case (word)
                     WORD_START: begin
                        notifying_in = 1'b0;
                        flushing_in  = 1'b0;
                        loading_in   = 1'b1;
                     end
                     WORD_CLIENT: begin
                        client_id_in = val[15:0];
                        notify_ch_in = val[31:16];
                     end
                     WORD_ROM_LO:  rom_start_in  = {rom_start_ff[63:32], val};
                     WORD_ROM_HI:  rom_start_in  = {val, rom_start_ff[31:0]};
                     WORD_DEST_LO: dest_start_in = {dest_start_ff[63:32], val};
                     WORD_DEST_HI: dest_start_in = {val, dest_start_ff[31:0]};
                     WORD_LEN_LO:  range_len_in  = {range_len_ff[63:32], val};
                     WORD_LEN_HI:  range_len_in  = {val, range_len_ff[31:0]};
                     default: begin
                     end
                  endcase
               end
            end
            OP_TICK: begin
               // a flush started by this tick's last chunk can go out on a later tick, not this one
               if (do_flush) begin
                  flushing_in = 1'b0;
               end
               if (do_load) begin
                  if (chunk_done) begin
                     loading_in  = 1'b0;
                     flushing_in = 1'b1;
                     progress_in = 64'd0;
                  end else begin
                     progress_in = progress_ff + {{(64-LINE_W){1'b0}}, chunk};
                  end
               end
               if (do_notify) begin
                  notifying_in = 1'b0;
               end
            end
            OP_FLUSH_RESP: begin
               if (!resp_bad) begin
                  notifying_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // result queue: load on transfer, else shift on output transfer
   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         slot_in[i] = slot_ff[i];
      end
      if (accept) begin
         count_in = res_cnt;
         for (int i = 0; i < MAX_RESULTS; i++) begin
            slot_in[i] = res[i];
         end
      end else if (pop) begin
         count_in = count_ff - RES_CNT_W'(1);
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            slot_in[i] = slot_ff[i + 1];
         end
      end
   end

   // configuration writes; reset client and channel are taken but not stored, and reset
   // loads zero ids, so they never reach the engine
   always_comb begin
      rom_bytes_in = rom_bytes_ff;
      own_id_in    = own_id_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_ROM_BYTES:     rom_bytes_in = csr_wdata[ROM_BYTES_W-1:0];
            CSR_OWN_DEVICE_ID: own_id_in    = csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rom_bytes_ff  <= ROM_BYTES_RESET;
         own_id_ff     <= '0;
         loading_ff    <= 1'b0;
         flushing_ff   <= 1'b0;
         notifying_ff  <= 1'b0;
         client_id_ff  <= '0;
         notify_ch_ff  <= '0;
         rom_start_ff  <= '0;
         dest_start_ff <= '0;
         range_len_ff  <= '0;
         progress_ff   <= '0;
         count_ff      <= '0;
      end else begin
         rom_bytes_ff  <= rom_bytes_in;
         own_id_ff     <= own_id_in;
         loading_ff    <= loading_in;
         flushing_ff   <= flushing_in;
         notifying_ff  <= notifying_in;
         client_id_ff  <= client_id_in;
         notify_ch_ff  <= notify_ch_in;
         rom_start_ff  <= rom_start_in;
         dest_start_ff <= dest_start_in;
         range_len_ff  <= range_len_in;
         progress_ff   <= progress_in;
         count_ff      <= count_in;
      end
   end

   // result payload slots
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

endmodule
`default_nettype wire

>>> bench/rom_dma_line_loader_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rom_dma_line_loader_test: self-checking bench for the ROM DMA line loader
// Sends register writes, ROM reads, engine ticks and flush replies with random
// handshake gaps on both sides, predicts every bus result at the input transfer
// and checks the results in order, field by field.
// ----------------------------------------------------------------------------
module rom_dma_line_loader_test;
   import rdl_pkg::*;

   localparam int              CLOCK_PERIOD    = 20;
   localparam int              IDLE_LIMIT      = 3000;
   localparam int              RSP_HOLD_CYCLES = 200;
   localparam int              TAIL_CYCLES     = 8;
   localparam int              PHASE_ITEMS     = 115;
   localparam int              REPORT_LIMIT    = 100;
   localparam logic [63:0]     LINE_SPAN       = 64'(LINE_BYTES);

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // predicted engine state
   logic        ln_loading;
   logic        ln_flushing;
   logic        ln_notifying;
   logic [15:0] ln_client;
   logic [15:0] ln_channel;
   logic [63:0] ln_rom_start;
   logic [63:0] ln_dest_start;
   logic [63:0] ln_length;
   logic [63:0] ln_progress;

   // configuration copy; the reset ids only matter at reset, which is not repeated
   logic [ROM_BYTES_W-1:0] cfg_rom_bytes;
   logic [15:0]            cfg_reset_client;
   logic [15:0]            cfg_reset_channel;
   logic [15:0]            cfg_own_id;

   rsp_type awaited_results[$];
   rsp_type oldest_result;
   int      error_count;
   int      sent_items;
   int      idle_cycles;
   int      rsp_stall_left;
   bit      req_idle_on;
   bit      rsp_idle_on;
   bit      hold_pending;

   rom_dma_line_loader uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return $urandom_range(10, 40);
      if (roll < 6) return $urandom_range(1, 3);
      return 0;
   endfunction

   // bus ready bits of a tick, each high three times in four
   function automatic logic [2:0] ready_mix();
      logic [2:0] bits;
      bits[2] = ($urandom_range(0, 3) != 0);
      bits[1] = ($urandom_range(0, 3) != 0);
      bits[0] = ($urandom_range(0, 3) != 0);
      return bits;
   endfunction

   function automatic req_type make_req(op_type op, logic [63:0] addr, logic [31:0] value,
                                        logic [7:0] size, logic [15:0] src,
                                        logic [2:0] readies);
      req_type r;
      r.op            = op;
      r.req_address   = addr;
      r.write_value   = value;
      r.req_size      = size;
      r.source_device = src;
      r.write_ready   = readies[2];
      r.read_ready    = readies[1];
      r.notify_ready  = readies[0];
      return r;
   endfunction

   // work out the bus results of one accepted request and advance the engine state
   function automatic void predict_loader_results(req_type r);
      rsp_type     item;
      logic [63:0] remain;
      logic [63:0] dest;
      logic [63:0] to_edge;
      logic [63:0] chunk;
      logic        do_load;
      logic        do_flush;
      logic        do_notify;
      logic        set_flush;
      logic [3:0]  word;
      int          produced;
      produced = 0;
      case (r.op)
         OP_REG_WRITE: begin
            if (r.req_address[1:0] != 2'b00 || r.req_address > REG_ADDR_MAX ||
                r.req_size != REG_SIZE) begin
               item = {KIND_ERROR, r.source_device, r.req_address, 64'd0, r.req_size, 1'b0};
               awaited_results.insert(awaited_results.size(), item);
               produced++;
            end else begin
               word = r.req_address[5:2];
               case (word)
                  WORD_START: begin
                     ln_notifying = 1'b0;
                     ln_flushing  = 1'b0;
                     ln_loading   = 1'b1;
                  end
                  WORD_CLIENT: begin
                     ln_client  = r.write_value[15:0];
                     ln_channel = r.write_value[31:16];
                  end
                  WORD_ROM_LO:  ln_rom_start[31:0]  = r.write_value;
                  WORD_ROM_HI:  ln_rom_start[63:32] = r.write_value;
                  WORD_DEST_LO: ln_dest_start[31:0]  = r.write_value;
                  WORD_DEST_HI: ln_dest_start[63:32] = r.write_value;
                  WORD_LEN_LO:  ln_length[31:0]  = r.write_value;
                  WORD_LEN_HI:  ln_length[63:32] = r.write_value;
                  default: ;
               endcase
            end
         end
         OP_ROM_READ: begin
            if (r.req_address >= {39'd0, cfg_rom_bytes} ||
                {56'd0, r.req_size} > {39'd0, cfg_rom_bytes} - r.req_address)
               item = {KIND_ERROR, r.source_device, r.req_address, 64'd0, r.req_size, 1'b0};
            else
               item = {KIND_READ_RESP, r.source_device, r.req_address, r.req_address,
                       r.req_size, 1'b0};
            awaited_results.insert(awaited_results.size(), item);
            produced++;
         end
         OP_TICK: begin
            // each engine acts on the flags as they stood before this tick
            do_load   = ln_loading & r.write_ready;
            do_flush  = ln_flushing & r.read_ready;
            do_notify = ln_notifying & r.notify_ready;
            set_flush = 1'b0;
            if (do_load) begin
               remain  = (ln_progress >= ln_length) ? 64'd0 : ln_length - ln_progress;
               dest    = ln_dest_start + ln_progress;
               to_edge = LINE_SPAN - (dest & (LINE_SPAN - 64'd1));
               chunk   = remain;
               if (chunk > LINE_SPAN) chunk = LINE_SPAN;
               if (chunk > to_edge) chunk = to_edge;
               item = {KIND_DMA_WRITE, ln_client, dest, ln_rom_start + ln_progress,
                       chunk[7:0], 1'b0};
               awaited_results.insert(awaited_results.size(), item);
               produced++;
               if (chunk < remain) begin
                  ln_progress = ln_progress + chunk;
               end else begin
                  set_flush   = 1'b1;
                  ln_loading  = 1'b0;
                  ln_progress = 64'd0;
               end
            end
            if (do_flush) begin
               item = {KIND_FLUSH_READ, ln_client, 64'd0, 64'd0, 8'd0, 1'b0};
               awaited_results.insert(awaited_results.size(), item);
               produced++;
               ln_flushing = 1'b0;
            end
            if (set_flush) ln_flushing = 1'b1;
            if (do_notify) begin
               item = {KIND_NOTIFY, ln_channel, {48'd0, cfg_own_id}, 64'd0, 8'd0, 1'b0};
               awaited_results.insert(awaited_results.size(), item);
               produced++;
               ln_notifying = 1'b0;
            end
         end
         default: begin
            // flush reply: only the client may answer, at address zero
            if (r.source_device != ln_client || r.req_address != 64'd0) begin
               item = {KIND_ERROR, r.source_device, r.req_address, 64'd0, r.req_size, 1'b0};
               awaited_results.insert(awaited_results.size(), item);
               produced++;
            end else begin
               ln_notifying = 1'b1;
            end
         end
      endcase
      if (produced > 0) awaited_results[awaited_results.size() - 1].last = 1'b1;
   endfunction

   // one request transfer; valid stays up after the transfer until the next falling edge
   task automatic send_item(req_type r);
      int gap;
      gap = req_idle_on ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_loader_results(r);
      sent_items++;
   endtask

   task automatic write_word(logic [3:0] word, logic [31:0] value);
      send_item(make_req(OP_REG_WRITE, {58'd0, word, 2'b00}, value, REG_SIZE,
                         16'($urandom_range(0, 65535)), 3'($urandom_range(0, 7))));
   endtask

   task automatic tick(logic [2:0] readies);
      send_item(make_req(OP_TICK, {$urandom, $urandom}, $urandom,
                         8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                         readies));
   endtask

   task automatic rom_read(logic [63:0] addr, logic [7:0] size);
      send_item(make_req(OP_ROM_READ, addr, $urandom, size, 16'($urandom_range(0, 65535)),
                         3'($urandom_range(0, 7))));
   endtask

   task automatic flush_reply(logic [15:0] src, logic [63:0] addr);
      send_item(make_req(OP_FLUSH_RESP, addr, $urandom, 8'($urandom_range(0, 255)), src,
                         3'($urandom_range(0, 7))));
   endtask

   // stop offering and wait until every predicted result has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(csr_idx_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_ROM_BYTES:     cfg_rom_bytes     = value;
         CSR_RESET_CLIENT:  cfg_reset_client  = value[15:0];
         CSR_RESET_CHANNEL: cfg_reset_channel = value[15:0];
         default:           cfg_own_id        = value[15:0];
      endcase
   endtask

   task automatic set_config(logic [CSR_DATA_W-1:0] capacity, logic [15:0] client,
                             logic [15:0] channel, logic [15:0] own_id);
      wait_drained();
      csr_write(CSR_ROM_BYTES, capacity);
      csr_write(CSR_RESET_CLIENT, {9'd0, client});
      csr_write(CSR_RESET_CHANNEL, {9'd0, channel});
      csr_write(CSR_OWN_DEVICE_ID, {9'd0, own_id});
   endtask

   // malformed register accesses, plus the spare word that does nothing
   task automatic test_register_errors();
      send_item(make_req(OP_REG_WRITE, 64'd2, 32'hffff_ffff, REG_SIZE, 16'h0001, 3'b111));
      send_item(make_req(OP_REG_WRITE, 64'd36, 32'h0, REG_SIZE, 16'hffff, 3'b000));
      send_item(make_req(OP_REG_WRITE, 64'hffff_ffff_ffff_fffc, 32'h1234_5678, REG_SIZE,
                         16'h8000, 3'b101));
      send_item(make_req(OP_REG_WRITE, 64'd4, 32'h5555_aaaa, 8'd3, 16'h0000, 3'b010));
      send_item(make_req(OP_REG_WRITE, 64'd8, 32'haaaa_5555, 8'hff, 16'h7fff, 3'b111));
      send_item(make_req(OP_REG_WRITE, REG_ADDR_MAX, 32'hffff_ffff, REG_SIZE, 16'h0, 3'b0));
   endtask

   // reads at and past the edges of the rom
   task automatic test_rom_reads();
      rom_read({39'd0, cfg_rom_bytes} - 64'd1, 8'd1);
      rom_read({39'd0, cfg_rom_bytes}, 8'd0);
      rom_read({39'd0, cfg_rom_bytes} - 64'd1, 8'd2);
      rom_read(64'd0, 8'hff);
      rom_read(64'hffff_ffff_ffff_ffff, 8'hff);
   endtask

   // flush replies from the wrong device or at a nonzero address
   task automatic test_flush_errors();
      flush_reply(ln_client ^ 16'hffff, 64'd0);
      flush_reply(ln_client, 64'h8000_0000_0000_0000);
   endtask

   task automatic test_load_cases();
      // zero length load gives one empty write, then the flush
      write_word(WORD_START, $urandom);
      tick(3'b111);
      tick(3'b000);
      // notification armed while the flush is still waiting
      flush_reply(ln_client, 64'd0);
      tick(3'b111);
      // unaligned destination: first chunk stops at the line edge
      write_word(WORD_DEST_LO, 32'h30);
      write_word(WORD_LEN_LO, 32'd200);
      write_word(WORD_ROM_LO, 32'h1000);
      write_word(WORD_START, 32'd0);
      tick(3'b011);
      tick(3'b111);
      // notify alongside a full line write
      flush_reply(ln_client, 64'd0);
      tick(3'b111);
      // restart resumes at the current progress
      write_word(WORD_START, 32'd0);
      tick(3'b111);
      // length cut below progress: empty write ends the load
      write_word(WORD_LEN_LO, 32'd100);
      tick(3'b111);
      tick(3'b111);
   endtask

   task automatic send_noise_item();
      logic [63:0] addr;
      logic [7:0]  size;
      logic [3:0]  word;
      logic [15:0] src;
      case ($urandom_range(0, 3))
         0: begin
            word = 4'($urandom_range(0, 9));
            if ($urandom_range(0, 1) == 0) addr = {58'd0, word, 2'b00};
            else if ($urandom_range(0, 1) == 0) addr = 64'($urandom_range(0, 40));
            else addr = {$urandom, $urandom};
            size = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : REG_SIZE;
            send_item(make_req(OP_REG_WRITE, addr, $urandom, size,
                               16'($urandom_range(0, 65535)), 3'($urandom_range(0, 7))));
         end
         1: begin
            case ($urandom_range(0, 2))
               0: addr = {$urandom, $urandom};
               1: addr = {39'd0, cfg_rom_bytes} - 64'($urandom_range(0, 300));
               default: addr = 64'($urandom_range(0, 4096));
            endcase
            rom_read(addr, 8'($urandom_range(0, 255)));
         end
         2: tick(ready_mix());
         default: begin
            src  = ($urandom_range(0, 1) == 0) ? ln_client : 16'($urandom_range(0, 65535));
            addr = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'd0;
            flush_reply(src, addr);
         end
      endcase
   endtask

   // a complete load: range setup, start, ticks to the flush, reply, notification
   task automatic run_random_load();
      int          guard;
      logic [31:0] len_lo;
      if ($urandom_range(0, 2) == 0) write_word(WORD_CLIENT, $urandom);
      write_word(WORD_ROM_LO, $urandom);
      write_word(WORD_ROM_HI, ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom);
      write_word(WORD_DEST_LO, ($urandom_range(0, 3) == 0) ? ($urandom & 32'hffff_ffc0)
                                                          : $urandom);
      write_word(WORD_DEST_HI, ($urandom_range(0, 3) == 0) ? 32'hffff_ffff : $urandom);
      case ($urandom_range(0, 9))
         0:       len_lo = 32'd0;
         8:       len_lo = $urandom_range(200, 700);
         9:       len_lo = $urandom;
         default: len_lo = $urandom_range(1, 200);
      endcase
      write_word(WORD_LEN_LO, len_lo);
      write_word(WORD_LEN_HI, ($urandom_range(0, 19) == 0) ? $urandom : 32'd0);
      write_word(WORD_START, $urandom);
      guard = 0;
      while ((ln_loading || ln_flushing) && guard < 48) begin
         if ($urandom_range(0, 19) == 0) send_noise_item();
         else if ($urandom_range(0, 39) == 0) write_word(WORD_LEN_LO, $urandom_range(0, 100));
         else tick(ready_mix());
         guard++;
      end
      if ($urandom_range(0, 7) == 0)
         flush_reply(16'($urandom_range(0, 65535)), {$urandom, $urandom});
      else flush_reply(ln_client, 64'd0);
      guard = 0;
      while (ln_notifying && guard < 8) begin
         tick(ready_mix());
         guard++;
      end
   endtask

   task automatic test_random_traffic(int quota);
      int target;
      target = sent_items + quota;
      while (sent_items < target) begin
         if ($urandom_range(0, 3) == 0) send_noise_item();
         else run_random_load();
      end
   endtask

   // receiver stalls long enough to fill the block while reads keep coming
   task automatic test_backpressure();
      wait_drained();
      req_idle_on  = 1'b0;
      hold_pending = 1'b1;
      repeat (24) rom_read(64'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      wait_drained();
      req_idle_on = 1'b1;
   endtask

   // receiver side: random stalls, or one long hold on request
   initial begin
      rsp_ready      = 1'b0;
      rsp_stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            rsp_ready <= 1'b1;
         end else if (rsp_stall_left > 0) begin
            rsp_ready <= 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_idle_on) rsp_stall_left = pick_gap();
         end
      end
   end

   task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // result check on every transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
         end else begin
            oldest_result = awaited_results.pop_front();
            compare_field("kind", 64'(oldest_result.kind), 64'(rsp_data.kind));
            compare_field("target_device", 64'(oldest_result.target_device),
                          64'(rsp_data.target_device));
            compare_field("bus_address", oldest_result.bus_address, rsp_data.bus_address);
            compare_field("byte_offset", oldest_result.byte_offset, rsp_data.byte_offset);
            compare_field("length", 64'(oldest_result.length), 64'(rsp_data.length));
            compare_field("last", 64'(oldest_result.last), 64'(rsp_data.last));
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      hold_pending = 1'b0;
      req_idle_on  = 1'b1;
      rsp_idle_on  = 1'b1;
      error_count  = 0;
      sent_items   = 0;
      idle_cycles  = 0;
      // state after reset
      ln_loading        = 1'b0;
      ln_flushing       = 1'b0;
      ln_notifying      = 1'b0;
      cfg_rom_bytes     = ROM_BYTES_RESET;
      cfg_reset_client  = 16'd0;
      cfg_reset_channel = 16'd0;
      cfg_own_id        = 16'd0;
      ln_client         = cfg_reset_client;
      ln_channel        = cfg_reset_channel;
      ln_rom_start      = 64'd0;
      ln_dest_start     = 64'd0;
      ln_length         = 64'd0;
      ln_progress       = 64'd0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_register_errors();
      test_rom_reads();
      test_flush_errors();
      test_load_cases();

      // small rom, all-ones ids, no idling on either side
      set_config(25'd1, 16'hffff, 16'hffff, 16'hffff);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      test_random_traffic(PHASE_ITEMS);

      // 16 MiB rom, zero ids
      set_config(25'h100_0000, 16'h0, 16'h0, 16'h0);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      test_random_traffic(PHASE_ITEMS);

      // random size and ids, receiver stalls only
      set_config(25'($urandom_range(1, 25'h100_0000)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      req_idle_on = 1'b0;
      test_random_traffic(PHASE_ITEMS);

      set_config(ROM_BYTES_RESET, 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      req_idle_on = 1'b1;
      test_random_traffic(PHASE_ITEMS);

      test_backpressure();

      wait_drained();
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> filelist.f
design/rdl_pkg.sv
design/rom_dma_line_loader.sv
bench/rom_dma_line_loader_test.sv
